>>> hdl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared constants, command codes and control types of the complex ALU.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int WORD_BITS_DEF     = 32;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int FIELD_BITS        = 32;
  localparam int TOL_BITS          = 16;
  localparam int CMD_BITS          = 3;

  // register index as decoded from paddr[2]
  localparam logic REG_EQUAL_TOL = 1'b0;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_NEG = 3'd4,
    CMD_CMP = 3'd5
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic dz;
    logic neg_re;
    logic neg_im;
  } ctl_t;

endpackage

>>> hdl/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// Operand capture, partial products, sums and the short commands.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; #(
  parameter int W = WORD_BITS_DEF,
  parameter int F = FRACTION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  cmd_t                         command,
  input  logic signed [FIELD_BITS-1:0] a_re,
  input  logic signed [FIELD_BITS-1:0] a_im,
  input  logic signed [FIELD_BITS-1:0] b_re,
  input  logic signed [FIELD_BITS-1:0] b_im,
  input  logic [TOL_BITS-1:0]          tolerance,
  output logic                         out_valid,
  output ctl_t                         ctl,
  output logic [2*W-1:0]               num_re,
  output logic [2*W-1:0]               num_im,
  output logic [2*W-1:0]               den,
  output logic signed [W-1:0]          quick_re,
  output logic signed [W-1:0]          quick_im,
  output logic                         quick_ovf,
  output logic                         quick_eq
);

  localparam logic [W-1:0]   MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]   MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [2*W:0]   RND  = (2*W+1)'(1) << (F-1);
  localparam logic [2*W:0]   LIM  = (2*W+1)'(1) << (W-1);

  // stage 0: operands
  logic                v0;
  cmd_t                cmd0;
  logic signed [W-1:0] ar, ai, br, bi;

  // stage 1: products and linear results
  logic                  v1;
  cmd_t                  cmd1;
  logic signed [2*W-1:0] p_rr, p_ii, p_ir, p_ri, s_rr, s_ii;
  logic signed [W:0]     lin_re, lin_im;
  logic                  eq1;

  // stage 2: sums
  logic                v2;
  cmd_t                cmd2;
  logic signed [2*W:0] x_re, x_im;
  logic [2*W-1:0]      den2;
  logic [W-1:0]        sat_re, sat_im;
  logic                lin_ovf, eq2;

  logic signed [W:0] lin_re_c, lin_im_c, d_re, d_im;
  logic [W:0]        abs_re, abs_im;
  logic [W:0]        rs_re, rs_im;

  function automatic logic [W:0] round_sat(input logic signed [2*W:0] x);
    logic [2*W-1:0] mag;
    logic [2*W:0]   rm;
    logic           ovf;
    logic [W-1:0]   v;
    mag = x[2*W] ? (2*W)'(-x) : (2*W)'(x);
    rm  = ({1'b0, mag} + RND) >> F;
    if (x[2*W]) begin
      ovf = rm > LIM;
      v   = ovf ? MINV : W'(-rm);
    end else begin
      ovf = rm >= LIM;
      v   = ovf ? MAXV : rm[W-1:0];
    end
    return {ovf, v};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd0 <= command;
      ar   <= W'(a_re);
      ai   <= W'(a_im);
      br   <= W'(b_re);
      bi   <= W'(b_im);
    end
  end

  always_comb begin
    d_re   = (W+1)'(ar) - (W+1)'(br);
    d_im   = (W+1)'(ai) - (W+1)'(bi);
    abs_re = d_re[W] ? $unsigned(-d_re) : $unsigned(d_re);
    abs_im = d_im[W] ? $unsigned(-d_im) : $unsigned(d_im);
    unique case (cmd0)
      CMD_ADD: begin
        lin_re_c = (W+1)'(ar) + (W+1)'(br);
        lin_im_c = (W+1)'(ai) + (W+1)'(bi);
      end
      CMD_NEG: begin
        lin_re_c = -(W+1)'(ar);
        lin_im_c = -(W+1)'(ai);
      end
      default: begin
        lin_re_c = d_re;
        lin_im_c = d_im;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1   <= cmd0;
      p_rr   <= ar * br;
      p_ii   <= ai * bi;
      p_ir   <= ai * br;
      p_ri   <= ar * bi;
      s_rr   <= br * br;
      s_ii   <= bi * bi;
      lin_re <= lin_re_c;
      lin_im <= lin_im_c;
      eq1    <= (cmd0 == CMD_CMP) && (abs_re <= (W+1)'(tolerance))
                && (abs_im <= (W+1)'(tolerance));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd2 <= cmd1;
      if (cmd1 == CMD_MUL) begin
        x_re <= (2*W+1)'(p_rr) - (2*W+1)'(p_ii);
        x_im <= (2*W+1)'(p_ir) + (2*W+1)'(p_ri);
      end else begin
        x_re <= (2*W+1)'(p_rr) + (2*W+1)'(p_ii);
        x_im <= (2*W+1)'(p_ir) - (2*W+1)'(p_ri);
      end
      den2 <= $unsigned(s_rr) + $unsigned(s_ii);
      // two-bit sign disagreement means the linear result left the word range
      sat_re <= (lin_re[W] ^ lin_re[W-1]) ? (lin_re[W] ? MINV : MAXV) : lin_re[W-1:0];
      sat_im <= (lin_im[W] ^ lin_im[W-1]) ? (lin_im[W] ? MINV : MAXV) : lin_im[W-1:0];
      lin_ovf <= (cmd1 == CMD_ADD || cmd1 == CMD_SUB || cmd1 == CMD_NEG)
                 && ((lin_re[W] ^ lin_re[W-1]) || (lin_im[W] ^ lin_im[W-1]));
      eq2 <= eq1;
    end
  end

  assign rs_re = round_sat(x_re);
  assign rs_im = round_sat(x_im);

  always_ff @(posedge clk) begin
    if (en) begin
      ctl.cmd    <= cmd2;
      ctl.dz     <= (cmd2 == CMD_DIV) && (den2 == '0);
      ctl.neg_re <= x_re[2*W];
      ctl.neg_im <= x_im[2*W];
      num_re     <= x_re[2*W] ? (2*W)'(-x_re) : (2*W)'(x_re);
      num_im     <= x_im[2*W] ? (2*W)'(-x_im) : (2*W)'(x_im);
      den        <= den2;
      quick_eq   <= eq2;
      unique case (cmd2)
        CMD_ADD, CMD_SUB, CMD_NEG: begin
          quick_re  <= sat_re;
          quick_im  <= sat_im;
          quick_ovf <= lin_ovf;
        end
        CMD_MUL: begin
          quick_re  <= rs_re[W-1:0];
          quick_im  <= rs_im[W-1:0];
          quick_ovf <= rs_re[W] | rs_im[W];
        end
        default: begin
          quick_re  <= '0;
          quick_im  <= '0;
          quick_ovf <= 1'b0;
        end
      endcase
    end
  end

endmodule

>>> hdl/cau_div.sv
// ----------------------------------------------------------------------------
// cau_div
// Pipelined restoring divider, one quotient bit per stage for both parts.
// ----------------------------------------------------------------------------
module cau_div import cau_pkg::*; #(
  parameter int W  = WORD_BITS_DEF,
  parameter int F  = FRACTION_BITS_DEF,
  parameter int PW = 2*W+2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  ctl_t            ctl_in,
  input  logic [2*W-1:0]  num_re,
  input  logic [2*W-1:0]  num_im,
  input  logic [2*W-1:0]  den,
  input  logic [PW-1:0]   pass_in,
  output logic            out_valid,
  output ctl_t            ctl_out,
  output logic [W+1:0]    q_re,
  output logic [W+1:0]    q_im,
  output logic [PW-1:0]   pass_out
);

  localparam int NS = W + 2;
  localparam int RW = ((3*W > 2*W+F) ? 3*W : 2*W+F) + 1;

  logic            v_s    [0:NS];
  ctl_t            ctl_s  [0:NS];
  logic [PW-1:0]   pass_s [0:NS];
  logic [RW-1:0]   r_re   [0:NS];
  logic [RW-1:0]   r_im   [0:NS];
  logic [W+1:0]    qr_s   [0:NS];
  logic [W+1:0]    qi_s   [0:NS];
  logic [2*W-1:0]  den_s  [0:NS-1];

  // dividend carries the fraction shift plus one bit for rounding
  assign v_s[0]    = in_valid;
  assign ctl_s[0]  = ctl_in;
  assign pass_s[0] = pass_in;
  assign r_re[0]   = RW'(num_re) << (F+1);
  assign r_im[0]   = RW'(num_im) << (F+1);
  assign qr_s[0]   = '0;
  assign qi_s[0]   = '0;
  assign den_s[0]  = den;

  for (genvar g = 0; g < NS; g++) begin : g_stage
    localparam int K = W + 1 - g;
    logic [RW-1:0] dsh;
    logic          take_re, take_im;

    assign dsh     = RW'(den_s[g]) << K;
    assign take_re = r_re[g] >= dsh;
    assign take_im = r_im[g] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[g+1] <= 1'b0;
      end else if (en) begin
        v_s[g+1] <= v_s[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl_s[g+1]  <= ctl_s[g];
        pass_s[g+1] <= pass_s[g];
        r_re[g+1]   <= take_re ? r_re[g] - dsh : r_re[g];
        r_im[g+1]   <= take_im ? r_im[g] - dsh : r_im[g];
        qr_s[g+1]   <= {qr_s[g][W:0], take_re};
        qi_s[g+1]   <= {qi_s[g][W:0], take_im};
      end
    end

    if (g < NS-1) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          den_s[g+1] <= den_s[g];
        end
      end
    end
  end

  assign out_valid = v_s[NS];
  assign ctl_out   = ctl_s[NS];
  assign pass_out  = pass_s[NS];
  assign q_re      = qr_s[NS];
  assign q_im      = qi_s[NS];

endmodule

>>> hdl/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex ALU on signed fixed-point words: add, sub, mul, div,
// negate and tolerance compare, with saturation and divide-by-zero flag.
//
//  channel | dir | signals                   | contents
//  s_*     | in  | tvalid tready tdata tuser | operands a, b and command
//  m_*     | out | tvalid tready tdata tuser | result parts and flags
//  apb     | in  | psel penable pwrite ...   | equal_tolerance at address 0
//
// one beat per cycle in and out while the output is not stalled; every beat passes
// the front stages, the divider's stages (one quotient bit per stage) and the output register
// every command runs through the same pipe, so results leave in order
// rst clears valid bits and the tolerance register; no clearing pass
// a stalled output holds the whole pipe; s_tready drops only then
// ----------------------------------------------------------------------------
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int WORD_BITS     = WORD_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // a_re, a_im, b_re, b_im
  input  logic [2:0]   s_tuser,   // command
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // res_re, res_im
  output logic [2:0]   m_tuser,   // is_equal, div_by_zero, overflowed
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int W  = WORD_BITS;
  localparam int PW = 2*W + 2;
  localparam logic [W+1:0] LIM  = (W+2)'(1) << (W-1);
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic                en;
  logic [TOL_BITS-1:0] tol;

  logic                f_valid;
  ctl_t                f_ctl;
  logic [2*W-1:0]      f_num_re, f_num_im, f_den;
  logic signed [W-1:0] f_re, f_im;
  logic                f_ovf, f_eq;

  logic                d_valid;
  ctl_t                d_ctl;
  logic [W+1:0]        d_qre, d_qim;
  logic [PW-1:0]       d_pass;

  logic [W:0]          dv_re, dv_im;
  logic signed [W-1:0] res_re, res_im;
  logic                is_equal, div_by_zero, overflowed;

  function automatic logic [W:0] div_round(input logic [W+1:0] q, input logic neg);
    logic [W+1:0] mq;
    logic         ovf;
    logic [W-1:0] v;
    mq = (W+2)'(({1'b0, q} + (W+3)'(1)) >> 1);
    if (neg) begin
      ovf = mq > LIM;
      v   = ovf ? MINV : W'(-mq);
    end else begin
      ovf = mq >= LIM;
      v   = ovf ? MAXV : mq[W-1:0];
    end
    return {ovf, v};
  endfunction

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_EQUAL_TOL) ? 32'(tol) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_EQUAL_TOL) begin
      tol <= pwdata[TOL_BITS-1:0];
    end
  end

  cau_front #(.W(W), .F(FRACTION_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .command   (cmd_t'(s_tuser)),
    .a_re      (s_tdata[31:0]),
    .a_im      (s_tdata[63:32]),
    .b_re      (s_tdata[95:64]),
    .b_im      (s_tdata[127:96]),
    .tolerance (tol),
    .out_valid (f_valid),
    .ctl       (f_ctl),
    .num_re    (f_num_re),
    .num_im    (f_num_im),
    .den       (f_den),
    .quick_re  (f_re),
    .quick_im  (f_im),
    .quick_ovf (f_ovf),
    .quick_eq  (f_eq)
  );

  cau_div #(.W(W), .F(FRACTION_BITS), .PW(PW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .ctl_in    (f_ctl),
    .num_re    (f_num_re),
    .num_im    (f_num_im),
    .den       (f_den),
    .pass_in   ({f_eq, f_ovf, f_im, f_re}),
    .out_valid (d_valid),
    .ctl_out   (d_ctl),
    .q_re      (d_qre),
    .q_im      (d_qim),
    .pass_out  (d_pass)
  );

  assign dv_re = div_round(d_qre, d_ctl.neg_re);
  assign dv_im = div_round(d_qim, d_ctl.neg_im);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (d_ctl.cmd == CMD_DIV && d_ctl.dz) begin
        res_re      <= '0;
        res_im      <= '0;
        is_equal    <= 1'b0;
        div_by_zero <= 1'b1;
        overflowed  <= 1'b0;
      end else if (d_ctl.cmd == CMD_DIV) begin
        res_re      <= dv_re[W-1:0];
        res_im      <= dv_im[W-1:0];
        is_equal    <= 1'b0;
        div_by_zero <= 1'b0;
        overflowed  <= dv_re[W] | dv_im[W];
      end else begin
        res_re      <= d_pass[W-1:0];
        res_im      <= d_pass[2*W-1:W];
        overflowed  <= d_pass[2*W];
        is_equal    <= d_pass[2*W+1];
        div_by_zero <= 1'b0;
      end
    end
  end

  assign m_tdata = {32'(res_im), 32'(res_re)};
  assign m_tuser = {overflowed, div_by_zero, is_equal};

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata == '0 && !m_tuser[2] && !m_tuser[0])
    else $error("divide by zero beat carries a nonzero result");

  a_eq_alone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[2])
    else $error("compare beat carries data or overflow");

  a_tol_write: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr[2] == REG_EQUAL_TOL |=> tol == $past(pwdata[15:0]))
    else $error("tolerance register missed a write");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule
